// ----- rtl/hex_pair_credential_field_parser_defines.svh -----
// Assertion macros used by the credential field parser RTL.
`ifndef HEX_PAIR_CREDENTIAL_FIELD_PARSER_DEFINES_SVH
`define HEX_PAIR_CREDENTIAL_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HPCFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpcfp: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define HPCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpcfp: next-cycle check failed");

`endif

// ----- rtl/hpcfp_pkg.sv -----
// Types, codes and limits of the credential field parser.
package hpcfp_pkg;

  localparam int unsigned PHASE_W = 3;
  localparam int unsigned IDX_W   = 7;

  localparam logic [IDX_W-1:0] NAME_MAX     = 7'd32;
  localparam logic [IDX_W-1:0] PASSWORD_MAX = 7'd64;
  localparam logic [IDX_W-1:0] TOKEN_MAX    = 7'd32;
  localparam logic [IDX_W-1:0] CHECK_MAX    = 7'd1;

  localparam logic [PHASE_W-1:0] PH_SECURITY = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAME     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PASSWORD = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TOKEN    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CHECK    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_HEX  = 2'd1;
  localparam logic [1:0] ST_BAD_SEC  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic ACT_FEED    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [7:0] CH_SEP   = 8'h2F;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_HEX_A = 8'h41;
  localparam logic [7:0] CH_HEX_F = 8'h46;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [IDX_W-1:0]   byte_index;
    logic               expect_high;
    logic [3:0]         high_nibble;
  } hpcfp_state_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               write_valid;
    logic [PHASE_W-1:0] target;
    logic [IDX_W-1:0]   position;
    logic [7:0]         value;
    logic [PHASE_W-1:0] phase;
  } hpcfp_result_t;

endpackage

// ----- rtl/hpcfp_step.sv -----
// Per-character parse step: next parser state and the result of one transaction.
module hpcfp_step (
  input  logic                  action,
  input  logic [7:0]            code,
  input  hpcfp_pkg::hpcfp_state_t  cur,
  output hpcfp_pkg::hpcfp_state_t  nxt,
  output hpcfp_pkg::hpcfp_result_t res
);
  import hpcfp_pkg::*;

  logic                is_dig;
  logic                is_hex_af;
  logic [3:0]          nib;
  logic [IDX_W-1:0]    limit;
  logic                limit_ok;

  always_comb begin
    unique case (cur.phase)
      PH_NAME:     begin limit = NAME_MAX;     limit_ok = 1'b1; end
      PH_PASSWORD: begin limit = PASSWORD_MAX; limit_ok = 1'b1; end
      PH_TOKEN:    begin limit = TOKEN_MAX;    limit_ok = 1'b1; end
      PH_CHECK:    begin limit = CHECK_MAX;    limit_ok = 1'b1; end
      default:     begin limit = '0;           limit_ok = 1'b0; end
    endcase
  end

  always_comb begin
    is_dig    = (code >= CH_DIG_0) && (code <= CH_DIG_9);
    is_hex_af = (code >= CH_HEX_A) && (code <= CH_HEX_F);
    nib       = is_dig ? code[3:0] : (code[3:0] + 4'd9);

    nxt = cur;
    res = '0;

    if (action == ACT_RESTART) begin
      nxt.phase      = PH_SECURITY;
      nxt.byte_index = '0;
    end else if (code == CH_SEP) begin
      if (cur.phase >= PH_NAME && cur.phase <= PH_TOKEN) begin
        res.write_valid = 1'b1;
        res.target      = cur.phase;
        res.position    = cur.byte_index;
      end
      if (cur.phase <= PH_TOKEN) begin
        nxt.phase = cur.phase + 3'd1;
      end
      nxt.byte_index  = '0;
      nxt.expect_high = 1'b1;
    end else if (!is_dig && !is_hex_af) begin
      res.status = ST_NOT_HEX;
    end else if (cur.phase == PH_SECURITY) begin
      // security digit must be 0 or a single set bit
      if ($onehot0(nib)) begin
        res.write_valid = 1'b1;
        res.value       = {4'd0, nib};
      end else begin
        res.status = ST_BAD_SEC;
      end
    end else if (cur.expect_high) begin
      nxt.high_nibble = nib;
      nxt.expect_high = 1'b0;
    end else begin
      nxt.expect_high = 1'b1;
      if (!limit_ok) begin
        res.status = ST_NOT_HEX;
      end else if (cur.byte_index >= limit) begin
        res.status = ST_OVERFLOW;
      end else begin
        res.write_valid = 1'b1;
        res.target      = cur.phase;
        res.position    = cur.byte_index;
        res.value       = {cur.high_nibble, nib};
        nxt.byte_index  = cur.byte_index + 7'd1;
      end
    end

    res.phase = nxt.phase;
  end

endmodule

// ----- rtl/hex_pair_credential_field_parser.sv -----
// Top level of the hex-pair credential field parser.
// One transaction in, one transaction out: every character or restart gives exactly
// one result, and a new character is taken every cycle unless the input side stalls.
// Each one is held in the input register, parsed by the single parse stage and
// written to the result register; the parse stage also updates the phase, index
// and nibble state. A stalled result holds the parse stage; the input side stalls
// only when both registers are full and the result is stalled.
`include "hex_pair_credential_field_parser_defines.svh"

module hex_pair_credential_field_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_write_valid,
  output logic [2:0] out_target,
  output logic [6:0] out_position,
  output logic [7:0] out_value,
  output logic [2:0] out_phase
);
  import hpcfp_pkg::*;

  logic          s1_valid_r;
  logic          s1_action_r;
  logic [7:0]    s1_code_r;
  hpcfp_state_t  state_r;
  hpcfp_state_t  state_nxt;
  hpcfp_result_t res_nxt;
  hpcfp_result_t res_r;
  logic          out_valid_r;
  logic          out_free;
  logic          s1_adv;
  logic          in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  hpcfp_step u_step (
    .action (s1_action_r),
    .code   (s1_code_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_code_r   <= in_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_SECURITY;
      state_r.byte_index  <= '0;
      state_r.expect_high <= 1'b1;
      state_r.high_nibble <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_write_valid = res_r.write_valid;
  assign out_target      = res_r.target;
  assign out_position    = res_r.position;
  assign out_value       = res_r.value;
  assign out_phase       = res_r.phase;

  `HPCFP_ASSERT_NOW(a_phase_range, clk, rst_n, 1'b1, state_r.phase <= PH_CHECK)
  `HPCFP_ASSERT_NOW(a_index_range, clk, rst_n, 1'b1, state_r.byte_index <= PASSWORD_MAX)
  `HPCFP_ASSERT_NOW(a_nowrite_zero, clk, rst_n,
    out_valid_r && !res_r.write_valid,
    res_r.target == '0 && res_r.position == '0 && res_r.value == '0)
  `HPCFP_ASSERT_NOW(a_err_nowrite, clk, rst_n,
    out_valid_r && res_r.status != ST_OK, !res_r.write_valid)
  `HPCFP_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !out_free,
    s1_valid_r && $stable(s1_code_r) && $stable(state_r))

endmodule
